// File: rtl/cevq_pkg.sv
// cevq_pkg: request codes and payload structs for the coalescing event queue
// used by coalescing_event_queue and its port checker; no dependencies

package cevq_pkg;

  // request codes carried in req_type
  localparam logic [1:0] REQ_EVENT   = 2'd0;
  localparam logic [1:0] REQ_DEQUEUE = 2'd1;
  localparam logic [1:0] REQ_REMOVE  = 2'd2;

  // fixed field widths of the request and result
  localparam int unsigned SRC_W     = 4;
  localparam int unsigned OVR_W     = 16;
  localparam int unsigned OUT_CNT_W = 32;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [SRC_W-1:0] source_id;
    logic [OVR_W-1:0] overrun;
  } req_t;

  typedef struct packed {
    logic                 found;
    logic [SRC_W-1:0]     out_source;
    logic [OUT_CNT_W-1:0] out_count;
    logic                 queue_nonempty;
  } res_t;

endpackage

// File: rtl/coalescing_event_queue.sv
// coalescing_event_queue: pending-event fifo for timer sources, with coalesced counts
// depends on cevq_pkg for request codes and the request/result structs
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------
//   request  | start_i high, busy_o low| req_i  (cevq_pkg::req_t)
//   result   | done_o strobe, 1 cycle | res_o  (cevq_pkg::res_t)
//
// one request is taken every cycle; its result passes through the input
// register, then one pass of cell logic into the result register. busy_o
// stays low: each request finishes in one pass over the queue cells. reset
// empties the queue at once, no clearing pass. the result side cannot stall,
// so each done_o strobe lasts exactly one cycle.
//
// the queue is a row of cells kept in fifo order (cell 0 is the oldest);
// each cell holds a source and its count, since a count is nonzero exactly
// while its source is queued. removal shifts the younger cells down by one.

module coalescing_event_queue #(
  parameter int unsigned NUM_SOURCES = 16,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  cevq_pkg::req_t req_i,
  output logic           done_o,
  output cevq_pkg::res_t res_o
);

  localparam int unsigned IDX_W  = $clog2(NUM_SOURCES);
  localparam int unsigned LEN_W  = $clog2(NUM_SOURCES + 1);
  localparam int unsigned SUM_W  = ((COUNT_BITS > 17) ? COUNT_BITS : 17) + 1;
  localparam int unsigned HEAD_W = (COUNT_BITS > 32) ? COUNT_BITS : 33;
  localparam logic [SUM_W-1:0] CNT_MAX_EXT =
    {{(SUM_W - COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

  // input register
  logic           vld_q;
  cevq_pkg::req_t req_q;

  // queue cells
  logic [IDX_W-1:0]      src_q [NUM_SOURCES];
  logic [COUNT_BITS-1:0] cnt_q [NUM_SOURCES];
  logic [LEN_W-1:0]      len_q, len_d;

  // result register
  logic           done_q;
  cevq_pkg::res_t res_q, res_d;

  logic                  sid_ok;
  logic [IDX_W-1:0]      sidx;
  logic [NUM_SOURCES-1:0] match, pre_match, shift;
  logic                  hit;
  logic [COUNT_BITS-1:0] hit_cnt, new_cnt;
  logic [SUM_W-1:0]      sum;
  logic [HEAD_W-1:0]     head_ext;
  logic                  do_event, do_deq, do_rem;

  assign busy_o = 1'b0;

  // request capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_i;
    end
  end

  // source decode and range check
  assign sid_ok = (9'(req_q.source_id) < 9'(NUM_SOURCES));
  assign sidx   = IDX_W'(req_q.source_id);

  // match the requested source against the live cells
  always_comb begin
    hit_cnt = '0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      match[i] = (LEN_W'(i) < len_q) && (src_q[i] == sidx);
      hit_cnt  = hit_cnt | (match[i] ? cnt_q[i] : '0);
    end
  end

  assign hit = |match;

  // cells at or above the matched one move down on a remove
  for (genvar g = 0; g < NUM_SOURCES; g++) begin : g_pre
    assign pre_match[g] = |match[g:0];
  end

  assign do_event = vld_q && (req_q.req_type == cevq_pkg::REQ_EVENT) && sid_ok;
  assign do_deq   = vld_q && (req_q.req_type == cevq_pkg::REQ_DEQUEUE) && (len_q != '0);
  assign do_rem   = vld_q && (req_q.req_type == cevq_pkg::REQ_REMOVE) && sid_ok && hit;

  assign shift = do_deq ? '1 : (do_rem ? pre_match : '0);

  // saturating count update
  assign sum     = SUM_W'(hit ? hit_cnt : '0) + SUM_W'(req_q.overrun) + SUM_W'(1);
  assign new_cnt = (sum > CNT_MAX_EXT) ? '1 : sum[COUNT_BITS-1:0];

  // queue length after this request
  always_comb begin
    len_d = len_q;
    if (do_event && !hit) begin
      len_d = len_q + LEN_W'(1);
    end else if (do_deq || do_rem) begin
      len_d = len_q - LEN_W'(1);
    end
  end

  // head count clipped to the result width
  assign head_ext = HEAD_W'(cnt_q[0]);

  always_comb begin
    res_d                = '0;
    res_d.queue_nonempty = (len_d != '0);
    if (do_deq) begin
      res_d.found      = 1'b1;
      res_d.out_source = cevq_pkg::SRC_W'(src_q[0]);
      res_d.out_count  = (head_ext > HEAD_W'(32'hFFFF_FFFF)) ? '1
                                                             : head_ext[31:0];
    end
  end

  // cell update: shift down, bump a matched count or append at the tail
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (shift[i]) begin
        if (i < NUM_SOURCES - 1) begin
          src_q[i] <= src_q[(i + 1) % NUM_SOURCES];
          cnt_q[i] <= cnt_q[(i + 1) % NUM_SOURCES];
        end
      end else if (do_event && hit && match[i]) begin
        cnt_q[i] <= new_cnt;
      end else if (do_event && !hit && (len_q == LEN_W'(i))) begin
        src_q[i] <= sidx;
        cnt_q[i] <= new_cnt;
      end
    end
  end

  // control state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      done_q <= 1'b0;
    end else begin
      len_q  <= vld_q ? len_d : len_q;
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: rtl/cevq_checker.sv
// cevq_checker: port-level assertions for coalescing_event_queue, bound to the top
// depends on cevq_pkg for request codes and the request/result structs

module cevq_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input cevq_pkg::req_t req_i,
  input logic           done_o,
  input cevq_pkg::res_t res_o
);

  // every accepted request gives its result through the input and result registers
  a_req_to_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("accepted request produced no result");

  // no result without an earlier accepted request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result strobe without a request");

  // only a dequeue can report a popped source
  a_found_deq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.found) |-> ($past(req_i.req_type, 2) == cevq_pkg::REQ_DEQUEUE))
    else $error("found set on a non-dequeue request");

  // results of other requests carry zero source and count
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.found) |-> (res_o.out_source == '0 && res_o.out_count == '0))
    else $error("nonzero payload without a popped source");

  // a popped source always had a count of at least one
  a_found_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.found) |-> (res_o.out_count != '0))
    else $error("popped source with zero count");

endmodule

bind coalescing_event_queue cevq_checker u_cevq_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .req_i   (req_i),
  .done_o  (done_o),
  .res_o   (res_o)
);

// File: tb/testbench.sv
// testbench: self-checking bench for coalescing_event_queue, drives requests and
// checks each result against a behavioral queue predictor; depends on cevq_pkg

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  REQ_UNKNOWN  = 2'd3;
  localparam int unsigned NSRC         = 16;
  localparam logic [31:0] CNT_MAX      = 32'hFFFF_FFFF;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned RAND_ITEMS   = 1200;
  localparam int unsigned CALM_ITEMS   = 200;
  localparam int unsigned SAT_EVENTS   = 16;

  typedef struct {
    cevq_pkg::req_t req;
    bit             may_idle;
  } stim_t;

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  logic           busy_o;
  cevq_pkg::req_t req_i;
  logic           done_o;
  cevq_pkg::res_t res_o;

  coalescing_event_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // requests waiting for the driver, and results waiting for the dut
  stim_t          request_queue[$];
  cevq_pkg::res_t expected_results[$];

  // predictor state: sources in fifo order plus per-source counts
  logic [3:0]  pending_order[$];
  logic [31:0] source_count[NSRC];

  int unsigned requests_queued;
  int unsigned requests_taken;
  int unsigned results_checked;
  int unsigned pops_found;
  int unsigned saturating_events;
  int unsigned mismatches;
  int unsigned idle_left;
  int unsigned quiet_cycles;
  bit          req_taken;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // apply one request to the predictor and return the result it should give
  function automatic cevq_pkg::res_t queue_model_step(cevq_pkg::req_t r);
    cevq_pkg::res_t res;
    logic [32:0]    sum;
    logic [3:0]     s;
    int             pos;
    res   = '0;
    s     = r.source_id;
    case (r.req_type)
      cevq_pkg::REQ_EVENT: begin
        sum = {1'b0, source_count[s]} + {17'd0, r.overrun} + 33'd1;
        if (sum > {1'b0, CNT_MAX}) begin
          source_count[s] = CNT_MAX;
          saturating_events++;
        end else begin
          source_count[s] = sum[31:0];
        end
        pos = -1;
        foreach (pending_order[i]) if (pending_order[i] == s) pos = i;
        if (pos < 0) pending_order.push_back(s);
      end
      cevq_pkg::REQ_DEQUEUE: begin
        if (pending_order.size() != 0) begin
          s              = pending_order.pop_front();
          res.found      = 1'b1;
          res.out_source = s;
          res.out_count  = source_count[s];
          source_count[s] = '0;
          pops_found++;
        end
      end
      cevq_pkg::REQ_REMOVE: begin
        pos = -1;
        foreach (pending_order[i]) if (pending_order[i] == s) pos = i;
        if (pos >= 0) pending_order.delete(pos);
        source_count[s] = '0;
      end
      default: ;
    endcase
    res.queue_nonempty = (pending_order.size() != 0);
    return res;
  endfunction

  function automatic cevq_pkg::req_t make_req(logic [1:0] kind, logic [3:0] src,
                                              logic [15:0] ovr);
    cevq_pkg::req_t r;
    r.req_type  = kind;
    r.source_id = src;
    r.overrun   = ovr;
    return r;
  endfunction

  function automatic void add_request(cevq_pkg::req_t r, bit may_idle);
    stim_t st;
    st.req      = r;
    st.may_idle = may_idle;
    request_queue.push_back(st);
    requests_queued++;
  endfunction

  // random request with weighted kind, hot sources and spread-out overruns
  function automatic cevq_pkg::req_t random_req(int unsigned event_weight);
    int unsigned pick;
    logic [1:0]  kind;
    logic [3:0]  src;
    logic [15:0] ovr;
    pick = $urandom_range(0, 99);
    if (pick < event_weight) kind = cevq_pkg::REQ_EVENT;
    else if (pick < event_weight + (100 - event_weight) / 2) kind = cevq_pkg::REQ_DEQUEUE;
    else if (pick < 95) kind = cevq_pkg::REQ_REMOVE;
    else kind = REQ_UNKNOWN;
    if ($urandom_range(0, 9) < 6) src = 4'($urandom_range(0, 3));
    else src = 4'($urandom_range(0, NSRC - 1));
    case ($urandom_range(0, 9))
      0:             ovr = 16'h0000;
      1:             ovr = 16'hFFFF;
      2, 3, 4, 5:    ovr = 16'($urandom_range(0, 15));
      default:       ovr = 16'($urandom);
    endcase
    return make_req(kind, src, ovr);
  endfunction

  function automatic void note_mismatch(string field, logic [31:0] exp_v, logic [31:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
               results_checked, field, exp_v, got_v);
  endfunction

  // driver: new request or idle cycle on the falling edge
  always @(negedge clk_i) begin
    stim_t nxt;
    bit    go;
    if (rst_ni && (!start_i || req_taken)) begin
      go = 1'b0;
      if (idle_left != 0) begin
        idle_left--;
      end else if (request_queue.size() != 0) begin
        if (request_queue[0].may_idle && $urandom_range(0, 7) == 0) begin
          idle_left = $urandom_range(1, 19) - 1;
        end else begin
          nxt = request_queue.pop_front();
          go  = 1'b1;
        end
      end
      start_i <= go;
      if (go) req_i <= nxt.req;
    end
  end

  // monitor: predict on each accepted request, check each result strobe
  always @(posedge clk_i) begin
    cevq_pkg::res_t exp_r;
    req_taken = 1'b0;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        req_taken = 1'b1;
        requests_taken++;
        expected_results.push_back(queue_model_step(req_i));
      end
      if (done_o) begin
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected result", 32'd0, 32'd1);
        end else begin
          exp_r = expected_results.pop_front();
          if (res_o.found !== exp_r.found)
            note_mismatch("found", 32'(exp_r.found), 32'(res_o.found));
          if (res_o.out_source !== exp_r.out_source)
            note_mismatch("out_source", 32'(exp_r.out_source), 32'(res_o.out_source));
          if (res_o.out_count !== exp_r.out_count)
            note_mismatch("out_count", exp_r.out_count, res_o.out_count);
          if (res_o.queue_nonempty !== exp_r.queue_nonempty)
            note_mismatch("queue_nonempty", 32'(exp_r.queue_nonempty),
                          32'(res_o.queue_nonempty));
        end
        results_checked++;
      end
    end
  end

  // watchdog: too long without a request or a result taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned event_weight;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    requests_queued = 0;
    requests_taken  = 0;
    results_checked = 0;
    pops_found      = 0;
    saturating_events = 0;
    mismatches      = 0;
    idle_left       = 0;
    quiet_cycles    = 0;
    req_taken       = 1'b0;
    foreach (source_count[i]) source_count[i] = '0;

    // directed: empty pops, unqueued remove, unknown request, coalescing,
    // removal from middle, tail, head and of the only entry
    add_request(make_req(cevq_pkg::REQ_DEQUEUE, 4'd0,  16'h0000), 1'b1);
    add_request(make_req(cevq_pkg::REQ_REMOVE,  4'd5,  16'hFFFF), 1'b1);
    add_request(make_req(REQ_UNKNOWN,           4'd15, 16'hFFFF), 1'b1);
    add_request(make_req(cevq_pkg::REQ_EVENT,   4'd0,  16'h0000), 1'b1);
    add_request(make_req(cevq_pkg::REQ_EVENT,   4'd15, 16'hFFFF), 1'b1);
    add_request(make_req(cevq_pkg::REQ_EVENT,   4'd0,  16'h0005), 1'b1);
    add_request(make_req(cevq_pkg::REQ_EVENT,   4'd7,  16'h8000), 1'b1);
    add_request(make_req(cevq_pkg::REQ_EVENT,   4'd3,  16'h0001), 1'b1);
    add_request(make_req(cevq_pkg::REQ_REMOVE,  4'd7,  16'h0000), 1'b1);
    add_request(make_req(cevq_pkg::REQ_REMOVE,  4'd3,  16'h0000), 1'b1);
    add_request(make_req(cevq_pkg::REQ_EVENT,   4'd3,  16'h5555), 1'b1);
    add_request(make_req(cevq_pkg::REQ_EVENT,   4'd10, 16'hAAAA), 1'b1);
    add_request(make_req(cevq_pkg::REQ_REMOVE,  4'd0,  16'h0000), 1'b1);
    add_request(make_req(REQ_UNKNOWN,           4'd3,  16'h0000), 1'b1);
    add_request(make_req(cevq_pkg::REQ_DEQUEUE, 4'd9,  16'h1234), 1'b1);
    add_request(make_req(cevq_pkg::REQ_DEQUEUE, 4'd0,  16'h0000), 1'b1);
    add_request(make_req(cevq_pkg::REQ_DEQUEUE, 4'd0,  16'h0000), 1'b1);
    add_request(make_req(cevq_pkg::REQ_DEQUEUE, 4'd0,  16'h0000), 1'b1);
    add_request(make_req(cevq_pkg::REQ_DEQUEUE, 4'd0,  16'h0000), 1'b1);
    add_request(make_req(cevq_pkg::REQ_EVENT,   4'd9,  16'h0000), 1'b1);
    add_request(make_req(cevq_pkg::REQ_REMOVE,  4'd9,  16'h0000), 1'b1);
    add_request(make_req(cevq_pkg::REQ_EVENT,   4'd4,  16'h00FF), 1'b1);
    add_request(make_req(cevq_pkg::REQ_REMOVE,  4'd9,  16'h0000), 1'b1);
    add_request(make_req(cevq_pkg::REQ_DEQUEUE, 4'd0,  16'h0000), 1'b1);

    // heavy events on one source: large overruns pile up in one pending entry
    for (int unsigned i = 0; i < SAT_EVENTS; i++)
      add_request(make_req(cevq_pkg::REQ_EVENT, 4'd12, 16'hFFFF), 1'b0);
    add_request(make_req(cevq_pkg::REQ_EVENT,   4'd12, 16'hFFFE), 1'b0);
    add_request(make_req(cevq_pkg::REQ_EVENT,   4'd12, 16'h0000), 1'b0);
    add_request(make_req(cevq_pkg::REQ_EVENT,   4'd6,  16'h0001), 1'b0);
    add_request(make_req(cevq_pkg::REQ_EVENT,   4'd12, 16'hFFFF), 1'b0);
    add_request(make_req(cevq_pkg::REQ_DEQUEUE, 4'd0,  16'h0000), 1'b0);
    add_request(make_req(cevq_pkg::REQ_DEQUEUE, 4'd0,  16'h0000), 1'b0);

    // random traffic, the mix drifts between filling and draining
    event_weight = 50;
    for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
      if (i % 100 == 0) event_weight = $urandom_range(30, 70);
      add_request(random_req(event_weight), i < RAND_ITEMS - CALM_ITEMS);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // wait for all requests, then all results, then a short drain
    while (requests_taken != requests_queued) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d requests and checked %0d results", requests_taken, results_checked);
    $display("%0d pops returned a source, %0d events hit the count ceiling, %0d mismatches",
             pops_found, saturating_events, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/cevq_pkg.sv
rtl/coalescing_event_queue.sv
rtl/cevq_checker.sv
tb/testbench.sv
